>>> rtl/core/dapg_pkg.sv
// shared types and instruction constants for the debug access program generator
`default_nettype none

package dapg_pkg;

    typedef enum logic [1:0] {
        MODE_READ_START = 2'd0,
        MODE_READ_NEXT  = 2'd1,
        MODE_READ_END   = 2'd2,
        MODE_WRITE      = 2'd3
    } mode_t;

    // address bits 31:29
    localparam logic [2:0] WIDTH_BYTE = 3'd0;
    localparam logic [2:0] WIDTH_HALF = 3'd1;
    localparam logic [2:0] WIDTH_WORD = 3'd2;

    localparam logic [15:0] UPPER_BASE = 16'ha000;

    localparam logic [31:0] OP_LUI_R3   = 32'h3c030000;
    localparam logic [31:0] OP_LBU      = 32'h90620000;
    localparam logic [31:0] OP_LHU      = 32'h94620000;
    localparam logic [31:0] OP_LW       = 32'h8c620000;
    localparam logic [31:0] OP_ZERO_R2  = 32'h00001025;
    localparam logic [31:0] OP_RETURN   = 32'h03e00008;
    localparam logic [31:0] OP_STORE_RS = 32'hac820000;
    localparam logic [31:0] OP_ORI_R2Z  = 32'h34020000;
    localparam logic [31:0] OP_SB       = 32'ha0620000;
    localparam logic [31:0] OP_SH       = 32'ha4620000;
    localparam logic [31:0] OP_LUI_R2   = 32'h3c020000;
    localparam logic [31:0] OP_ORI_R2R2 = 32'h34420000;
    localparam logic [31:0] OP_SW       = 32'hac620000;

    localparam int MAX_WORDS = 5;

    // one classified command, as handed from front to back
    typedef struct packed {
        mode_t       mode;
        logic        need_lui;
        logic [15:0] upper;
        logic [2:0]  width;
        logic [15:0] offset;
        logic [31:0] data;
    } desc_t;

endpackage

`default_nettype wire

>>> rtl/core/dapg_front.sv
// front end: accepts commands, resolves the upper-half cache, builds descriptors
`default_nettype none

module dapg_front
    import dapg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] address,
    input  wire logic [31:0] write_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        q_full,
    output logic             q_push,
    output desc_t            q_desc
);

    logic [15:0] cache_reg;
    logic [15:0] cache_next;
    logic [15:0] upper;
    mode_t       cmd_mode;
    logic        uses_addr;
    logic        need_lui;

    assign cmd_mode  = mode_t'(mode);
    assign upper     = {3'b000, address[28:16]} + {15'd0, address[15]} + UPPER_BASE;
    assign uses_addr = (cmd_mode != MODE_READ_END);
    assign need_lui  = uses_addr && (upper != cache_reg);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_desc.mode     = cmd_mode;
        q_desc.need_lui = need_lui;
        q_desc.upper    = upper;
        q_desc.width    = address[31:29];
        q_desc.offset   = address[15:0];
        q_desc.data     = write_data;
    end

    always_comb
    begin
        cache_next = cache_reg;
        if (q_push && need_lui)
        begin
            cache_next = upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_reg <= 16'd0;
        end
        else
        begin
            cache_reg <= cache_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dapg_queue.sv
// two-entry descriptor queue between front and back
`default_nettype none

module dapg_queue
    import dapg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_desc,
    output logic       full,
    input  wire logic  pop,
    output logic       not_empty,
    output desc_t      head
);

    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dapg_back.sv
// back end: expands the head descriptor into instruction words, one per cycle while out_stall is low
`default_nettype none

module dapg_back
    import dapg_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_not_empty,
    input  wire desc_t  q_head,
    output logic        q_pop,
    output logic [31:0] instruction_word,
    output logic        last,
    output logic        out_valid,
    input  wire logic   out_stall
);

    logic [31:0] words [MAX_WORDS];
    logic [2:0]  n;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic        load;
    logic        final_word;
    logic        valid_reg;
    logic        valid_next;
    logic [31:0] word_reg;
    logic        last_reg;
    logic [15:0] off_half;
    logic [15:0] off_word;
    logic [15:0] lo_data;
    logic        is_read;

    assign off_half = {q_head.offset[15:1], 1'b0};
    assign off_word = {q_head.offset[15:2], 2'b00};
    assign lo_data  = q_head.data[15:0];
    assign is_read  = (q_head.mode == MODE_READ_START) || (q_head.mode == MODE_READ_NEXT);

    // program for the head command, appended in order
    always_comb
    begin
        for (int i = 0; i < MAX_WORDS; i++)
        begin
            words[i] = OP_RETURN;
        end
        n = 3'd0;
        if (q_head.mode == MODE_READ_NEXT || q_head.mode == MODE_READ_END)
        begin
            words[n] = OP_STORE_RS;
            n = n + 3'd1;
        end
        if (q_head.need_lui)
        begin
            words[n] = OP_LUI_R3 | {16'd0, q_head.upper};
            n = n + 3'd1;
        end
        if (is_read)
        begin
            case (q_head.width)
                WIDTH_BYTE: words[n] = OP_LBU | {16'd0, q_head.offset};
                WIDTH_HALF: words[n] = OP_LHU | {16'd0, off_half};
                WIDTH_WORD: words[n] = OP_LW | {16'd0, off_word};
                default:    words[n] = OP_ZERO_R2;
            endcase
            n = n + 3'd1;
        end
        else if (q_head.mode == MODE_WRITE)
        begin
            case (q_head.width)
                WIDTH_BYTE:
                begin
                    words[n] = OP_ORI_R2Z | {24'd0, q_head.data[7:0]};
                    words[n + 3'd1] = OP_SB | {16'd0, q_head.offset};
                    n = n + 3'd2;
                end
                WIDTH_HALF:
                begin
                    words[n] = OP_ORI_R2Z | {16'd0, lo_data};
                    words[n + 3'd1] = OP_SH | {16'd0, off_half};
                    n = n + 3'd2;
                end
                WIDTH_WORD:
                begin
                    words[n] = OP_LUI_R2 | {16'd0, q_head.data[31:16]};
                    words[n + 3'd1] = OP_ORI_R2R2 | {16'd0, lo_data};
                    words[n + 3'd2] = OP_SW | {16'd0, off_word};
                    n = n + 3'd3;
                end
                default:
                begin
                    // unknown width stores nothing
                end
            endcase
        end
        words[n] = OP_RETURN;
    end

    assign load       = q_not_empty && (!valid_reg || !out_stall);
    assign final_word = (idx_reg == n);
    assign q_pop      = load && final_word;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = final_word ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= words[idx_reg];
            last_reg <= final_word;
        end
    end

    assign instruction_word = word_reg;
    assign last             = last_reg;
    assign out_valid        = valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/debug_access_program_generator_unit.sv
// top level of the debug access program generator
`default_nettype none

// Each accepted bus command (read start, read next, read end, write) becomes a
// short instruction program of one to five words, delivered in order on the
// output channel with last set on the closing return jump. The front end takes
// a command in any cycle that the two-entry descriptor queue has room, and
// keeps the upper-half cache current at that point, so commands can arrive
// back to back. The back end sends one word per cycle, while out_stall is low,
// through a registered output, so the output port sets the sustained rate.

module debug_access_program_generator_unit
    import dapg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] address,
    input  wire logic [31:0] write_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic [31:0]      instruction_word,
    output logic             last,
    output logic             out_valid,
    input  wire logic        out_stall
);

    desc_t push_desc;
    desc_t head_desc;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_not_empty;

    dapg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode),
        .address    (address),
        .write_data (write_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_desc     (push_desc)
    );

    dapg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_desc)
    );

    dapg_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_not_empty      (q_not_empty),
        .q_head           (head_desc),
        .q_pop            (q_pop),
        .instruction_word (instruction_word),
        .last             (last),
        .out_valid        (out_valid),
        .out_stall        (out_stall)
    );

endmodule

`default_nettype wire

>>> dv/debug_access_program_generator_unit_test.sv
// testbench for the debug access program generator: program predictor, command driver, word checker
module debug_access_program_generator_unit_test;
    import dapg_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } program_word_t;

    class program_scoreboard;
        logic [15:0]   cached_upper;
        program_word_t program_words[$];
        int            errors;
        int            commands;
        int            words_checked;
        int            upper_loads;

        function new();
            cached_upper  = '0;
            errors        = 0;
            commands      = 0;
            words_checked = 0;
            upper_loads   = 0;
        endfunction

        function void add_word(logic [31:0] word, logic is_last);
            program_words.push_back('{word: word, last: is_last});
        endfunction

        // uncached segment base, bumped when the signed offset is negative
        function void add_upper_load(logic [31:0] addr);
            logic [15:0] upper;
            upper = {3'b000, addr[28:16]} + {15'd0, addr[15]} + UPPER_BASE;
            if (upper != cached_upper) begin
                cached_upper = upper;
                upper_loads++;
                add_word(OP_LUI_R3 | {16'h0000, upper}, 1'b0);
            end
        endfunction

        function void add_read(logic [31:0] addr);
            add_upper_load(addr);
            case (addr[31:29])
                WIDTH_BYTE: add_word(OP_LBU | {16'h0000, addr[15:0]}, 1'b0);
                WIDTH_HALF: add_word(OP_LHU | {16'h0000, addr[15:1], 1'b0}, 1'b0);
                WIDTH_WORD: add_word(OP_LW | {16'h0000, addr[15:2], 2'b00}, 1'b0);
                default:    add_word(OP_ZERO_R2, 1'b0);
            endcase
        endfunction

        function void accept_command(mode_t cmd, logic [31:0] addr, logic [31:0] data);
            commands++;
            case (cmd)
                MODE_READ_START: add_read(addr);
                MODE_READ_NEXT:
                begin
                    add_word(OP_STORE_RS, 1'b0);
                    add_read(addr);
                end
                MODE_READ_END: add_word(OP_STORE_RS, 1'b0);
                default:
                begin
                    add_upper_load(addr);
                    case (addr[31:29])
                        WIDTH_BYTE:
                        begin
                            add_word(OP_ORI_R2Z | {24'h000000, data[7:0]}, 1'b0);
                            add_word(OP_SB | {16'h0000, addr[15:0]}, 1'b0);
                        end
                        WIDTH_HALF:
                        begin
                            add_word(OP_ORI_R2Z | {16'h0000, data[15:0]}, 1'b0);
                            add_word(OP_SH | {16'h0000, addr[15:1], 1'b0}, 1'b0);
                        end
                        WIDTH_WORD:
                        begin
                            add_word(OP_LUI_R2 | {16'h0000, data[31:16]}, 1'b0);
                            add_word(OP_ORI_R2R2 | {16'h0000, data[15:0]}, 1'b0);
                            add_word(OP_SW | {16'h0000, addr[15:2], 2'b00}, 1'b0);
                        end
                        default: ;
                    endcase
                end
            endcase
            add_word(OP_RETURN, 1'b1);
        endfunction

        function void check_word(logic [31:0] word, logic is_last);
            program_word_t want;
            if (program_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h last %b", $time, word, is_last);
            end
            else begin
                want = program_words.pop_front();
                words_checked++;
                if (word !== want.word) begin
                    errors++;
                    $display("%0t: instruction_word expected %h actual %h",
                             $time, want.word, word);
                end
                if (is_last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b (word %h)",
                             $time, want.last, is_last, want.word);
                end
            end
        endfunction
    endclass

    localparam int HOLD_CYCLES = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic [1:0]  mode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instruction_word;
    logic        last;
    logic        out_valid;
    logic        out_stall;

    program_scoreboard sb = new();
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_requests = 0;
    int holds_served = 0;
    logic [12:0] upper_pool [4] = '{13'h0000, 13'h1fff, 13'h0123, 13'h1000};

    debug_access_program_generator_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .mode             (mode),
        .address          (address),
        .write_data       (write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .instruction_word (instruction_word),
        .last             (last),
        .out_valid        (out_valid),
        .out_stall        (out_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_command(input mode_t cmd, input logic [31:0] addr,
                                input logic [31:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode       <= cmd;
        address    <= addr;
        write_data <= data;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.accept_command(cmd, addr, data);
    endtask

    // stop offering and let every outstanding program come out
    task automatic drain_programs();
        in_valid <= 1'b0;
        while (sb.program_words.size() != 0)
            @(posedge clk);
    endtask

    // mostly valid widths, often on a few shared segments so the cache hits
    function automatic logic [31:0] pick_address();
        logic [2:0]  sel;
        logic [12:0] upper;
        logic [31:0] noise;
        noise = $urandom;
        sel   = ($urandom_range(99) < 85) ? 3'($urandom_range(2)) : 3'($urandom_range(7, 3));
        upper = ($urandom_range(99) < 60) ? upper_pool[$urandom_range(3)] : noise[28:16];
        return {sel, upper, noise[15:0]};
    endfunction

    task automatic random_traffic(input int count);
        int sent;
        int burst;
        int pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                burst = $urandom_range(4);
                send_command(MODE_READ_START, pick_address(), $urandom);
                repeat (burst) send_command(MODE_READ_NEXT, pick_address(), $urandom);
                send_command(MODE_READ_END, $urandom, $urandom);
                sent += burst + 2;
            end
            else if (pick < 85)
            begin
                send_command(MODE_WRITE, pick_address(), $urandom);
                sent++;
            end
            else
            begin
                send_command(mode_t'($urandom_range(3)), $urandom, $urandom);
                sent++;
            end
        end
    endtask

    // output side: check each transfer, then decide the next stall
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid && !out_stall)
                sb.check_word(instruction_word, last);
            if (hold_requests != holds_served)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        mode       <= MODE_READ_START;
        address    <= '0;
        write_data <= '0;
        sender_idle_pct   = 29;
        receiver_idle_pct = 70;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every valid width and several invalid ones, offset sign carry, cache hit and miss, ignored fields
        send_command(MODE_READ_START, 32'h0000_0000, 32'h0000_0000);
        send_command(MODE_READ_START, 32'h0000_0001, 32'h0000_0000);
        send_command(MODE_READ_NEXT,  32'h2000_8003, 32'h0000_0000);
        send_command(MODE_READ_NEXT,  32'h4000_ffff, 32'h0000_0000);
        send_command(MODE_READ_END,   32'hffff_ffff, 32'hffff_ffff);
        send_command(MODE_READ_START, 32'h7fff_ffff, 32'h0000_0000);
        send_command(MODE_READ_START, 32'hffff_7fff, 32'h0000_0000);
        send_command(MODE_READ_END,   32'h0000_0000, 32'h0000_0000);
        send_command(MODE_WRITE,      32'h1fff_8000, 32'hffff_ffff);
        send_command(MODE_WRITE,      32'h3fff_8001, 32'h1234_5678);
        send_command(MODE_WRITE,      32'h5fff_7ffe, 32'hffff_ffff);
        send_command(MODE_WRITE,      32'h4000_0000, 32'h0000_0000);
        send_command(MODE_WRITE,      32'h6000_1234, 32'hffff_ffff);
        send_command(MODE_WRITE,      32'he000_1234, 32'h0000_0000);
        send_command(MODE_READ_START, 32'h8000_0000, 32'h0000_0000);
        send_command(MODE_READ_NEXT,  32'ha001_0000, 32'h0000_0000);
        send_command(MODE_READ_END,   32'h1234_5678, 32'h8765_4321);
        send_command(MODE_READ_START, 32'h0000_0000, 32'hffff_ffff);
        send_command(MODE_WRITE,      32'h0000_5555, 32'haaaa_aaaa);
        send_command(MODE_WRITE,      32'h2000_aaaa, 32'h5555_5555);
        send_command(MODE_WRITE,      32'h4aaa_5554, 32'h5555_aaaa);
        send_command(MODE_READ_END,   32'h0000_0000, 32'h0000_0000);

        random_traffic(115);
        drain_programs();

        sender_idle_pct   = 70;
        receiver_idle_pct = 29;
        random_traffic(115);
        drain_programs();

        // no idling; the output holds off for a while so the input backs up
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_requests++;
        random_traffic(130);
        drain_programs();
        repeat (20) @(posedge clk);

        if (sb.program_words.size() != 0)
        begin
            sb.errors += sb.program_words.size();
            $display("%0t: %0d program words never arrived", $time, sb.program_words.size());
        end
        $display("covered %0d commands over all modes and widths, %0d words checked",
                 sb.commands, sb.words_checked);
        $display("%0d upper-half loads; idle mixes, output hold-off and drain pauses run",
                 sb.upper_loads);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timed out with %0d words outstanding", sb.program_words.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
